@@ sv/pppmh_pkg.sv @@
package pppmh_pkg;

  localparam int P_W      = 17;
  localparam int E_W      = 18;
  localparam int TRK_W    = E_W + 3 * P_W;
  localparam int OP_W     = 20;
  localparam int SQ_W     = 2 * OP_W;
  localparam int ACC_W    = SQ_W + 1;
  localparam int RAD_W    = 38;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int LIM_W    = 16;
  localparam int RCP_SH   = 24;
  localparam int RCP_W    = RCP_SH + 1;
  localparam int PROD_W   = LIM_W + RCP_W;
  localparam int BIN_IDX_W = 6;

  localparam int PION_MSQ   = 19480;
  localparam int PROTON_MSQ = 880355;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TCHK,
    ST_SQ,
    ST_RSTART,
    ST_RWAIT,
    ST_TWR,
    ST_PINIT,
    ST_RDPI,
    ST_LDPI,
    ST_RDPR,
    ST_LDPR,
    ST_DIV1,
    ST_DIV2,
    ST_DIV3,
    ST_HRD,
    ST_HWR,
    ST_NEXT,
    ST_DRD,
    ST_DOUT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [RAD_W-1:0]   radicand;
  } rt_req_t;

  typedef struct packed {
    logic               done;
    logic [ROOT_W-1:0]  root;
  } rt_rsp_t;

endpackage

@@ sv/pppmh_isqrt.sv @@
module pppmh_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  pppmh_pkg::rt_req_t  req,
  output pppmh_pkg::rt_rsp_t  rsp
);

  localparam int CNT_W = $clog2(pppmh_pkg::ROOT_W + 1);

  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [pppmh_pkg::RAD_W-1:0] x_r, x_nxt;
  logic [pppmh_pkg::RAD_W-1:0] r_r, r_nxt;
  logic [pppmh_pkg::RAD_W-1:0] bit_r, bit_nxt;
  logic [pppmh_pkg::RAD_W-1:0] t;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    t        = r_r + bit_r;
    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(pppmh_pkg::ROOT_W);
      x_nxt   = req.radicand;
      r_nxt   = '0;
      bit_nxt = pppmh_pkg::RAD_W'(1) << (pppmh_pkg::RAD_W - 2);
    end else if (run_r) begin
      if (x_r >= t) begin
        x_nxt = x_r - t;
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = r_r[pppmh_pkg::ROOT_W-1:0];

endmodule

@@ sv/pppmh_track_mem.sv @@
module pppmh_track_mem #(
  parameter int AW = 8
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [pppmh_pkg::TRK_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [pppmh_pkg::TRK_W-1:0] rdata
);

  logic [pppmh_pkg::TRK_W-1:0] mem [2**AW];
  logic [pppmh_pkg::TRK_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/pppmh_hist_mem.sv @@
module pppmh_hist_mem #(
  parameter int DEPTH = 50,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [31:0]      rdata_r;

  // unwritten bins read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= vld_r[raddr] ? mem[raddr] : 32'd0;
  end

  assign rdata = rdata_r;

endmodule

@@ sv/pion_proton_pair_mass_histogram.sv @@
// Track beat: a kept track runs through the 5-step shared squarer and the root unit;
// a beat that keeps no track and does not close the event skips both.
// End of event: each pion-proton pair passes the squarer, root unit, reciprocal bin divide and
// histogram read-modify-write, a negative mass skipping the rest; then every bin is dumped.
// Synchronous active-low reset clears counts, overflow flag and histogram valid bits at once.
// Results are shown for one cycle on out_valid; the receiver cannot stall.
module pion_proton_pair_mass_histogram #(
  parameter int MAX_TRACKS    = 128,
  parameter int NUM_BINS      = 50,
  parameter int BIN_WIDTH_MEV = 100
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data,
  input  logic               start,
  output logic               busy,
  input  logic               in_track_valid,
  input  logic signed [16:0] in_momentum_x,
  input  logic signed [16:0] in_momentum_y,
  input  logic signed [16:0] in_momentum_z,
  input  logic signed [15:0] in_pion_sigma,
  input  logic signed [15:0] in_proton_sigma,
  input  logic signed [1:0]  in_charge_sign,
  input  logic               in_end_of_event,
  output logic               out_valid,
  output logic [5:0]         out_bin_index,
  output logic [31:0]        out_bin_count,
  output logic               out_last_bin,
  output logic               out_list_overflow
);

  localparam int AW    = $clog2(MAX_TRACKS);
  localparam int CW    = $clog2(MAX_TRACKS + 1);
  localparam int BA    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int LIMIT = NUM_BINS * BIN_WIDTH_MEV;
  localparam int RECIP = (1 << pppmh_pkg::RCP_SH) / BIN_WIDTH_MEV;
  localparam int OPW   = pppmh_pkg::OP_W;
  localparam int ACW   = pppmh_pkg::ACC_W;
  localparam int BIW   = pppmh_pkg::BIN_IDX_W;
  localparam int PW    = pppmh_pkg::P_W;
  localparam int EW    = pppmh_pkg::E_W;

  pppmh_pkg::state_t state_r, state_nxt;

  logic [6:0]       cut_r, cut_nxt;
  logic [CW-1:0]    pcnt_r, pcnt_nxt;
  logic [CW-1:0]    rcnt_r, rcnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             eoe_r, eoe_nxt;
  logic             store_r, store_nxt;
  logic             kind_r, kind_nxt;
  logic             pair_r, pair_nxt;
  logic [2:0]       step_r, step_nxt;
  logic signed [OPW-1:0] ops_r [4];
  logic signed [OPW-1:0] ops_nxt [4];
  logic signed [pppmh_pkg::SQ_W-1:0] sq_r, sq_nxt;
  logic signed [ACW-1:0] acc_r, acc_nxt;
  logic [pppmh_pkg::ROOT_W-1:0] m_r, m_nxt;
  logic [pppmh_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [BIW-1:0]   q0_r, q0_nxt;
  logic [BIW-1:0]   bin_r, bin_nxt;
  logic [BIW-1:0]   db_r, db_nxt;
  logic [AW-1:0]    i_r, i_nxt;
  logic [AW-1:0]    j_r, j_nxt;
  logic [EW-1:0]    pie_r, pie_nxt;
  logic signed [PW-1:0] pipx_r, pipx_nxt;
  logic signed [PW-1:0] pipy_r, pipy_nxt;
  logic signed [PW-1:0] pipz_r, pipz_nxt;

  logic             ov_r, ov_nxt;
  logic [5:0]       obin_r, obin_nxt;
  logic [31:0]      ocnt_r, ocnt_nxt;
  logic             olast_r, olast_nxt;
  logic             oovf_r, oovf_nxt;

  logic                         tm_we;
  logic [AW:0]                  tm_waddr;
  logic [pppmh_pkg::TRK_W-1:0]  tm_wdata;
  logic [AW:0]                  tm_raddr;
  logic [pppmh_pkg::TRK_W-1:0]  tm_rdata;
  logic                         hm_we;
  logic [BA-1:0]                hm_raddr;
  logic [31:0]                  hm_wdata;
  logic [31:0]                  hm_rdata;
  pppmh_pkg::rt_req_t           rt_req;
  pppmh_pkg::rt_rsp_t           rt_rsp;

  logic             accept;
  logic signed [16:0] spi, spr;
  logic [16:0]      abs_pi, abs_pr, lim;
  logic             pion_ok, prot_ok;
  logic [16:0]      rem;

  assign busy   = (state_r != pppmh_pkg::ST_IDLE) || ov_r;
  assign accept = start && !busy;

  always_comb begin
    spi     = 17'(in_pion_sigma);
    spr     = 17'(in_proton_sigma);
    abs_pi  = spi[16] ? 17'(-spi) : 17'(spi);
    abs_pr  = spr[16] ? 17'(-spr) : 17'(spr);
    lim     = {2'b00, cut_r, 8'h00};
    pion_ok = in_track_valid && (in_charge_sign == -2'sd1) && (abs_pi < lim);
    prot_ok = in_track_valid && (in_charge_sign == 2'sd1) && (abs_pr < lim);
  end

  always_comb begin
    state_nxt = state_r;
    cut_nxt   = cfg_wr_en ? cfg_wr_data : cut_r;
    pcnt_nxt  = pcnt_r;
    rcnt_nxt  = rcnt_r;
    ovf_nxt   = ovf_r;
    eoe_nxt   = eoe_r;
    store_nxt = store_r;
    kind_nxt  = kind_r;
    pair_nxt  = pair_r;
    step_nxt  = step_r;
    for (int k = 0; k < 4; k++) begin
      ops_nxt[k] = ops_r[k];
    end
    sq_nxt    = sq_r;
    acc_nxt   = acc_r;
    m_nxt     = m_r;
    prod_nxt  = prod_r;
    q0_nxt    = q0_r;
    bin_nxt   = bin_r;
    db_nxt    = db_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    pie_nxt   = pie_r;
    pipx_nxt  = pipx_r;
    pipy_nxt  = pipy_r;
    pipz_nxt  = pipz_r;
    ov_nxt    = 1'b0;
    obin_nxt  = obin_r;
    ocnt_nxt  = ocnt_r;
    olast_nxt = 1'b0;
    oovf_nxt  = oovf_r;
    tm_we     = 1'b0;
    tm_waddr  = {kind_r, kind_r ? rcnt_r[AW-1:0] : pcnt_r[AW-1:0]};
    tm_wdata  = {m_r[EW-1:0], ops_r[2][PW-1:0], ops_r[1][PW-1:0], ops_r[0][PW-1:0]};
    tm_raddr  = {1'b0, i_r};
    hm_we     = 1'b0;
    hm_raddr  = bin_r[BA-1:0];
    hm_wdata  = (hm_rdata == 32'hFFFF_FFFF) ? hm_rdata : hm_rdata + 32'd1;
    rt_req.start    = 1'b0;
    rt_req.radicand = acc_r[pppmh_pkg::RAD_W-1:0];
    rem       = 17'(q0_r) * 17'(BIN_WIDTH_MEV);
    rem       = 17'(m_r[pppmh_pkg::LIM_W-1:0]) - rem;

    case (state_r)
      pppmh_pkg::ST_IDLE: begin
        if (accept) begin
          ops_nxt[0] = OPW'(in_momentum_x);
          ops_nxt[1] = OPW'(in_momentum_y);
          ops_nxt[2] = OPW'(in_momentum_z);
          ops_nxt[3] = '0;
          eoe_nxt    = in_end_of_event;
          store_nxt  = 1'b0;
          kind_nxt   = prot_ok;
          if (pion_ok) begin
            if (pcnt_r == CW'(MAX_TRACKS)) ovf_nxt = 1'b1;
            else store_nxt = 1'b1;
          end
          if (prot_ok) begin
            if (rcnt_r == CW'(MAX_TRACKS)) ovf_nxt = 1'b1;
            else store_nxt = 1'b1;
          end
          state_nxt = pppmh_pkg::ST_TCHK;
        end
      end
      pppmh_pkg::ST_TCHK: begin
        if (store_r) begin
          pair_nxt  = 1'b0;
          step_nxt  = '0;
          acc_nxt   = kind_r ? ACW'(pppmh_pkg::PROTON_MSQ) : ACW'(pppmh_pkg::PION_MSQ);
          state_nxt = pppmh_pkg::ST_SQ;
        end else if (eoe_r) begin
          state_nxt = pppmh_pkg::ST_PINIT;
        end else begin
          state_nxt = pppmh_pkg::ST_IDLE;
        end
      end
      pppmh_pkg::ST_SQ: begin
        if (step_r != 3'd4) begin
          sq_nxt = ops_r[step_r[1:0]] * ops_r[step_r[1:0]];
        end
        if (step_r != 3'd0) begin
          if (pair_r && step_r != 3'd1) acc_nxt = acc_r - ACW'(sq_r);
          else acc_nxt = acc_r + ACW'(sq_r);
        end
        if (step_r == 3'd4) state_nxt = pppmh_pkg::ST_RSTART;
        else step_nxt = step_r + 3'd1;
      end
      pppmh_pkg::ST_RSTART: begin
        if (pair_r && acc_r[ACW-1]) begin
          state_nxt = pppmh_pkg::ST_NEXT;
        end else begin
          rt_req.start = 1'b1;
          state_nxt    = pppmh_pkg::ST_RWAIT;
        end
      end
      pppmh_pkg::ST_RWAIT: begin
        if (rt_rsp.done) begin
          m_nxt     = rt_rsp.root;
          state_nxt = pair_r ? pppmh_pkg::ST_DIV1 : pppmh_pkg::ST_TWR;
        end
      end
      pppmh_pkg::ST_TWR: begin
        tm_we     = 1'b1;
        store_nxt = 1'b0;
        if (kind_r) rcnt_nxt = rcnt_r + CW'(1);
        else pcnt_nxt = pcnt_r + CW'(1);
        state_nxt = eoe_r ? pppmh_pkg::ST_PINIT : pppmh_pkg::ST_IDLE;
      end
      pppmh_pkg::ST_PINIT: begin
        i_nxt  = '0;
        db_nxt = '0;
        if (pcnt_r == '0 || rcnt_r == '0) state_nxt = pppmh_pkg::ST_DRD;
        else state_nxt = pppmh_pkg::ST_RDPI;
      end
      pppmh_pkg::ST_RDPI: begin
        tm_raddr  = {1'b0, i_r};
        state_nxt = pppmh_pkg::ST_LDPI;
      end
      pppmh_pkg::ST_LDPI: begin
        pipx_nxt  = $signed(tm_rdata[PW-1:0]);
        pipy_nxt  = $signed(tm_rdata[2*PW-1:PW]);
        pipz_nxt  = $signed(tm_rdata[3*PW-1:2*PW]);
        pie_nxt   = tm_rdata[pppmh_pkg::TRK_W-1:3*PW];
        j_nxt     = '0;
        state_nxt = pppmh_pkg::ST_RDPR;
      end
      pppmh_pkg::ST_RDPR: begin
        tm_raddr  = {1'b1, j_r};
        state_nxt = pppmh_pkg::ST_LDPR;
      end
      pppmh_pkg::ST_LDPR: begin
        ops_nxt[0] = OPW'(pie_r) + OPW'(tm_rdata[pppmh_pkg::TRK_W-1:3*PW]);
        ops_nxt[1] = OPW'(pipx_r) + OPW'($signed(tm_rdata[PW-1:0]));
        ops_nxt[2] = OPW'(pipy_r) + OPW'($signed(tm_rdata[2*PW-1:PW]));
        ops_nxt[3] = OPW'(pipz_r) + OPW'($signed(tm_rdata[3*PW-1:2*PW]));
        acc_nxt    = '0;
        pair_nxt   = 1'b1;
        step_nxt   = '0;
        state_nxt  = pppmh_pkg::ST_SQ;
      end
      pppmh_pkg::ST_DIV1: begin
        if (m_r >= pppmh_pkg::ROOT_W'(LIMIT)) begin
          state_nxt = pppmh_pkg::ST_NEXT;
        end else begin
          prod_nxt  = pppmh_pkg::PROD_W'(m_r[pppmh_pkg::LIM_W-1:0])
                    * pppmh_pkg::PROD_W'(RECIP);
          state_nxt = pppmh_pkg::ST_DIV2;
        end
      end
      pppmh_pkg::ST_DIV2: begin
        q0_nxt    = prod_r[pppmh_pkg::RCP_SH +: BIW];
        state_nxt = pppmh_pkg::ST_DIV3;
      end
      pppmh_pkg::ST_DIV3: begin
        bin_nxt   = (rem >= 17'(BIN_WIDTH_MEV)) ? q0_r + BIW'(1) : q0_r;
        state_nxt = pppmh_pkg::ST_HRD;
      end
      pppmh_pkg::ST_HRD: begin
        hm_raddr  = bin_r[BA-1:0];
        state_nxt = pppmh_pkg::ST_HWR;
      end
      pppmh_pkg::ST_HWR: begin
        hm_we     = 1'b1;
        state_nxt = pppmh_pkg::ST_NEXT;
      end
      pppmh_pkg::ST_NEXT: begin
        if ((CW'(j_r) + CW'(1)) < rcnt_r) begin
          j_nxt     = j_r + AW'(1);
          state_nxt = pppmh_pkg::ST_RDPR;
        end else if ((CW'(i_r) + CW'(1)) < pcnt_r) begin
          i_nxt     = i_r + AW'(1);
          state_nxt = pppmh_pkg::ST_RDPI;
        end else begin
          db_nxt    = '0;
          state_nxt = pppmh_pkg::ST_DRD;
        end
      end
      pppmh_pkg::ST_DRD: begin
        hm_raddr  = db_r[BA-1:0];
        state_nxt = pppmh_pkg::ST_DOUT;
      end
      pppmh_pkg::ST_DOUT: begin
        ov_nxt    = 1'b1;
        obin_nxt  = db_r;
        ocnt_nxt  = hm_rdata;
        oovf_nxt  = ovf_r;
        if (db_r == BIW'(NUM_BINS - 1)) begin
          olast_nxt = 1'b1;
          pcnt_nxt  = '0;
          rcnt_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = pppmh_pkg::ST_IDLE;
        end else begin
          db_nxt    = db_r + BIW'(1);
          state_nxt = pppmh_pkg::ST_DRD;
        end
      end
      default: state_nxt = pppmh_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pppmh_pkg::ST_IDLE;
      cut_r   <= 7'd3;
      pcnt_r  <= '0;
      rcnt_r  <= '0;
      ovf_r   <= 1'b0;
      store_r <= 1'b0;
      ov_r    <= 1'b0;
      olast_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cut_r   <= cut_nxt;
      pcnt_r  <= pcnt_nxt;
      rcnt_r  <= rcnt_nxt;
      ovf_r   <= ovf_nxt;
      store_r <= store_nxt;
      ov_r    <= ov_nxt;
      olast_r <= olast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eoe_r  <= eoe_nxt;
    kind_r <= kind_nxt;
    pair_r <= pair_nxt;
    step_r <= step_nxt;
    for (int k = 0; k < 4; k++) begin
      ops_r[k] <= ops_nxt[k];
    end
    sq_r   <= sq_nxt;
    acc_r  <= acc_nxt;
    m_r    <= m_nxt;
    prod_r <= prod_nxt;
    q0_r   <= q0_nxt;
    bin_r  <= bin_nxt;
    db_r   <= db_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    pie_r  <= pie_nxt;
    pipx_r <= pipx_nxt;
    pipy_r <= pipy_nxt;
    pipz_r <= pipz_nxt;
    obin_r <= obin_nxt;
    ocnt_r <= ocnt_nxt;
    oovf_r <= oovf_nxt;
  end

  pppmh_track_mem #(
    .AW (AW + 1)
  ) u_track_mem (
    .clk   (clk),
    .we    (tm_we),
    .waddr (tm_waddr),
    .wdata (tm_wdata),
    .raddr (tm_raddr),
    .rdata (tm_rdata)
  );

  pppmh_hist_mem #(
    .DEPTH (NUM_BINS),
    .AW    (BA)
  ) u_hist_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (hm_we),
    .waddr (bin_r[BA-1:0]),
    .wdata (hm_wdata),
    .raddr (hm_raddr),
    .rdata (hm_rdata)
  );

  pppmh_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rt_req),
    .rsp   (rt_rsp)
  );

  assign out_valid         = ov_r;
  assign out_bin_index     = obin_r;
  assign out_bin_count     = ocnt_r;
  assign out_last_bin      = olast_r;
  assign out_list_overflow = oovf_r;

endmodule

@@ sv/pppmh_checker.sv @@
module pppmh_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [5:0] out_bin_index,
  input logic       out_last_bin
);

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat while not busy");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_bin |-> out_valid)
    else $error("last bin flag without a result beat");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_dump_pace: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_bin) |=> !out_valid ##1 out_valid)
    else $error("dump beats out of step");

  a_dump_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_bin) |-> ##2 (out_bin_index == $past(out_bin_index, 2) + 6'd1))
    else $error("bins not dumped in order");

endmodule

bind pion_proton_pair_mass_histogram pppmh_checker u_pppmh_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_bin_index (out_bin_index),
  .out_last_bin  (out_last_bin)
);
